// File: rtl/sdpg_pkg.sv
// shared constants, codes and controller/datapath interface types
`default_nettype none

package sdpg_pkg;

  localparam int POSITION_BITS = 24;
  localparam int INTERVAL_BITS = 20;

  localparam int FUNC_W     = 2;
  localparam int DIAL_W     = 11;
  localparam int TICK_W     = 10;
  localparam int CFG_IVL_W  = 20;
  localparam int RANGE_W    = 10;
  localparam int PMAX_W     = 23;
  localparam int PMIN_W     = 24;
  localparam int ANGLE_W    = 9;
  localparam int DEG_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = ((DIAL_W + 7) / 8) * 8;
  localparam int OUT_BITS    = 3 + POSITION_BITS + DEG_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CMP_W  = ((POSITION_BITS > PMIN_W) ? POSITION_BITS : PMIN_W) + 1;
  localparam int TCMP_W = (INTERVAL_BITS > TICK_W) ? INTERVAL_BITS : TICK_W;

  localparam int DEGP_W  = POSITION_BITS + ANGLE_W + 1;
  localparam int DEGS_W  = ((DEGP_W > PMAX_W) ? DEGP_W : PMAX_W) + 1;
  localparam int MAPP_W  = RANGE_W + 1 + CFG_IVL_W + 1;
  localparam int DIV_N   = ((DEGS_W - 1) > (MAPP_W - 1)) ? (DEGS_W - 1) : (MAPP_W - 1);
  localparam int DIV_D   = PMAX_W;
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);

  localparam logic [DIV_N-1:0] DEG_POS_LIMIT = DIV_N'((1 << (DEG_W - 1)) - 1);
  localparam logic [DIV_N-1:0] DEG_NEG_LIMIT = DIV_N'(1 << (DEG_W - 1));
  localparam logic [DEG_W-1:0] DEG_POS_SAT   = DEG_W'((1 << (DEG_W - 1)) - 1);
  localparam logic [DEG_W-1:0] DEG_NEG_SAT   = DEG_W'(1 << (DEG_W - 1));

  localparam logic [TICK_W-1:0]    RST_TICK_PERIOD = TICK_W'(10);
  localparam logic [CFG_IVL_W-1:0] RST_INTERVAL_MAX = CFG_IVL_W'(5000);
  localparam logic [CFG_IVL_W-1:0] RST_INTERVAL_MIN = CFG_IVL_W'(200);
  localparam logic [RANGE_W-1:0]   RST_DIAL_RANGE   = RANGE_W'(20);
  localparam logic [PMAX_W-1:0]    RST_MAX_POSITION = PMAX_W'(2000);
  localparam logic [PMIN_W-1:0]    RST_MIN_POSITION = PMIN_W'(-2000);
  localparam logic [ANGLE_W-1:0]   RST_MAX_ANGLE    = ANGLE_W'(105);

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIAL_RANGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POSITION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE    = 3'd6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_DIAL = 2'd1,
    FUNC_ZERO = 2'd2
  } sdpg_func_t;

  typedef struct packed {
    logic capture;
    logic map_mul;
    logic div_start;
    logic div_deg;
    logic apply;
    logic deg_mul;
    logic load_out;
  } sdpg_cmd_t;

  typedef struct packed {
    logic is_dial;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sdpg_sts_t;

endpackage

`default_nettype wire

// File: rtl/stepper_dial_pulse_generator_unit.sv
// top level of the stepper step/direction generator
// sequence: tick, zero and unused events run only the degree division; a dial event
//   runs the interval division first and then the degree division
// throughput: one item at a time, set by the shared 34-step serial divider
//   (interval mapping and degree conversion); the next item is taken while the result waits
// reset: synchronous active-low rst_n restores register defaults and clears motion state
`default_nettype none

module stepper_dial_pulse_generator_unit
  import sdpg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // dial
  input  wire logic [FUNC_W-1:0]      in_tuser,   // func
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // step_level, direction, position, position_deg, moving
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  sdpg_cmd_t cmd;
  sdpg_sts_t sts;

  sdpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sdpg_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

`default_nettype wire

// File: rtl/sdpg_div.sv
// iterative restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module sdpg_div
  import sdpg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_N-1:0] dividend,
  input  wire logic [DIV_D-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [DIV_N-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_N-1:0]     q_r, q_nxt;
  logic [DIV_D-1:0]     rem_r, rem_nxt;
  logic [DIV_D-1:0]     dvs_r, dvs_nxt;
  logic [DIV_D:0]       trial;
  logic                 fits;

  assign trial = {rem_r, q_r[DIV_N-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_N);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_D'(trial - {1'b0, dvs_r}) : trial[DIV_D-1:0];
      q_nxt   = {q_r[DIV_N-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// File: rtl/sdpg_datapath.sv
// configuration, motion state, multipliers, divider operands and output register
`default_nettype none

module sdpg_datapath
  import sdpg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sdpg_cmd_t              cmd,
  output sdpg_sts_t                   sts,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [FUNC_W-1:0]      in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic [TICK_W-1:0]    tick_r;
  logic [CFG_IVL_W-1:0] imax_r;
  logic [CFG_IVL_W-1:0] imin_r;
  logic [RANGE_W-1:0]   rng_r;
  logic [PMAX_W-1:0]    pmax_r;
  logic [PMIN_W-1:0]    pmin_r;
  logic [ANGLE_W-1:0]   angle_r;

  // motion state
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     dir_r, dir_nxt;
  logic                     en_r, en_nxt;
  logic                     pulse_r, pulse_nxt;
  logic [INTERVAL_BITS-1:0] cnt_r, cnt_nxt;
  logic [INTERVAL_BITS-1:0] tgt_r, tgt_nxt;

  // captured item and arithmetic
  logic [FUNC_W-1:0]        func_r;
  logic [DIAL_W-1:0]        dial_r;
  logic signed [MAPP_W-1:0] map_prod_r;
  logic                     map_neg_r;
  logic signed [DEGS_W-1:0] deg_prod_r;
  logic                     deg_neg_r;
  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;

  logic                     dial_neg;
  logic                     dial_pos;
  logic [DIAL_W-1:0]        dial_mag;
  logic [RANGE_W-1:0]       mag_cl;
  logic [RANGE_W-1:0]       mag_m1;
  logic [RANGE_W-1:0]       rng_m1;
  logic signed [CFG_IVL_W:0] ivl_diff;
  logic [MAPP_W-1:0]        map_mag;
  logic [CFG_IVL_W:0]       map_q;
  logic [CFG_IVL_W+1:0]     map_sum;
  logic [CFG_IVL_W-1:0]     ivl_cfg;
  logic [INTERVAL_BITS-1:0] ivl;

  logic signed [CMP_W-1:0]  pos_c;
  logic signed [CMP_W-1:0]  pmax_c;
  logic signed [CMP_W-1:0]  pmin_c;
  logic                     at_max;
  logic                     at_min;
  logic [POSITION_BITS-1:0] pos_step;
  logic                     cnt_le_tick;
  logic [INTERVAL_BITS-1:0] cnt_minus;
  logic                     new_dir;
  logic                     want;

  logic [PMAX_W-1:0]        pmax_half;
  logic signed [DEGS_W-1:0] deg_sum;
  logic [DEGS_W-1:0]        deg_mag;
  logic [DEG_W-1:0]         deg;

  logic             div_busy;
  logic             div_done;
  logic [DIV_N-1:0] div_q;
  logic [DIV_N-1:0] div_dividend;
  logic [DIV_D-1:0] div_divisor;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= RST_TICK_PERIOD;
      imax_r  <= RST_INTERVAL_MAX;
      imin_r  <= RST_INTERVAL_MIN;
      rng_r   <= RST_DIAL_RANGE;
      pmax_r  <= RST_MAX_POSITION;
      pmin_r  <= RST_MIN_POSITION;
      angle_r <= RST_MAX_ANGLE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TICK_PERIOD:  tick_r  <= cfg_data[TICK_W-1:0];
        REG_INTERVAL_MAX: imax_r  <= cfg_data[CFG_IVL_W-1:0];
        REG_INTERVAL_MIN: imin_r  <= cfg_data[CFG_IVL_W-1:0];
        REG_DIAL_RANGE:   rng_r   <= cfg_data[RANGE_W-1:0];
        REG_MAX_POSITION: pmax_r  <= cfg_data[PMAX_W-1:0];
        REG_MIN_POSITION: pmin_r  <= cfg_data[PMIN_W-1:0];
        REG_MAX_ANGLE:    angle_r <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // dial to interval mapping
  assign dial_neg = dial_r[DIAL_W-1];
  assign dial_pos = !dial_neg && (dial_r != '0);
  assign dial_mag = dial_neg ? DIAL_W'(-dial_r) : dial_r;
  assign mag_cl   = (dial_mag > {1'b0, rng_r}) ? rng_r : dial_mag[RANGE_W-1:0];
  assign mag_m1   = mag_cl - RANGE_W'(1);
  assign rng_m1   = rng_r - RANGE_W'(1);
  assign ivl_diff = signed'({1'b0, imin_r}) - signed'({1'b0, imax_r});
  assign map_mag  = map_prod_r[MAPP_W-1] ? MAPP_W'(-map_prod_r) : MAPP_W'(map_prod_r);
  assign map_q    = div_q[CFG_IVL_W:0];
  assign map_sum  = {2'b00, imax_r}
                  + (map_neg_r ? (CFG_IVL_W+2)'(-{1'b0, map_q}) : {1'b0, map_q});
  assign ivl_cfg  = (rng_r < RANGE_W'(2)) ? imin_r : map_sum[CFG_IVL_W-1:0];
  assign ivl      = INTERVAL_BITS'(ivl_cfg);

  // bounds and countdown
  assign pos_c       = CMP_W'(signed'(pos_r));
  assign pmax_c      = CMP_W'(signed'({1'b0, pmax_r}));
  assign pmin_c      = CMP_W'(signed'(pmin_r));
  assign at_max      = pos_c >= pmax_c;
  assign at_min      = pos_c <= pmin_c;
  assign pos_step    = dir_r ? pos_r - POSITION_BITS'(1) : pos_r + POSITION_BITS'(1);
  assign cnt_le_tick = TCMP_W'(cnt_r) <= TCMP_W'(tick_r);
  assign cnt_minus   = INTERVAL_BITS'(TCMP_W'(cnt_r) - TCMP_W'(tick_r));
  assign new_dir     = !dial_pos;
  assign want        = (dial_r != '0) && !(new_dir ? at_min : at_max);

  always_comb begin
    pos_nxt   = pos_r;
    dir_nxt   = dir_r;
    en_nxt    = en_r;
    pulse_nxt = pulse_r;
    cnt_nxt   = cnt_r;
    tgt_nxt   = tgt_r;
    case (func_r)
      FUNC_TICK: begin
        if (pulse_r) begin
          pulse_nxt = 1'b0;
          pos_nxt   = pos_step;
          cnt_nxt   = tgt_r;
        end else if (en_r && !(dir_r ? at_min : at_max)) begin
          if (cnt_le_tick) begin
            pulse_nxt = 1'b1;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_minus;
          end
        end
      end
      FUNC_DIAL: begin
        if (!want) begin
          en_nxt = 1'b0;
        end else if (new_dir != dir_r) begin
          if (pulse_r) begin
            pulse_nxt = 1'b0;
            pos_nxt   = pos_step;
          end
          dir_nxt = new_dir;
          cnt_nxt = ivl;
          tgt_nxt = ivl;
          en_nxt  = 1'b1;
        end else begin
          tgt_nxt = ivl;
          en_nxt  = 1'b1;
        end
      end
      FUNC_ZERO: begin
        en_nxt    = 1'b0;
        pulse_nxt = 1'b0;
        if (pulse_r) begin
          cnt_nxt = tgt_r;
        end
        pos_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      dir_r   <= 1'b0;
      en_r    <= 1'b0;
      pulse_r <= 1'b0;
      cnt_r   <= '0;
      tgt_r   <= INTERVAL_BITS'(RST_INTERVAL_MAX);
    end else if (cmd.apply) begin
      pos_r   <= pos_nxt;
      dir_r   <= dir_nxt;
      en_r    <= en_nxt;
      pulse_r <= pulse_nxt;
      cnt_r   <= cnt_nxt;
      tgt_r   <= tgt_nxt;
    end
  end

  // degree conversion operands
  assign pmax_half = {1'b0, pmax_r[PMAX_W-1:1]};
  assign deg_sum   = deg_prod_r + signed'(DEGS_W'(pmax_half));
  assign deg_mag   = deg_sum[DEGS_W-1] ? DEGS_W'(-deg_sum) : DEGS_W'(deg_sum);

  always_comb begin
    if (pmax_r == '0) begin
      deg = '0;
    end else if (deg_neg_r) begin
      deg = (div_q > DEG_NEG_LIMIT) ? DEG_NEG_SAT : DEG_W'(-div_q[DEG_W-1:0]);
    end else begin
      deg = (div_q > DEG_POS_LIMIT) ? DEG_POS_SAT : div_q[DEG_W-1:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_tuser;
      dial_r <= in_tdata[DIAL_W-1:0];
    end
    if (cmd.map_mul) begin
      map_prod_r <= signed'({1'b0, mag_m1}) * ivl_diff;
    end
    if (cmd.deg_mul) begin
      deg_prod_r <= signed'(pos_r) * signed'({1'b0, angle_r});
    end
    if (cmd.div_start && !cmd.div_deg) begin
      map_neg_r <= map_prod_r[MAPP_W-1];
    end
    if (cmd.div_start && cmd.div_deg) begin
      deg_neg_r <= deg_sum[DEGS_W-1];
    end
    if (cmd.load_out) begin
      out_tdata_r <= OUT_TDATA_W'({en_r, deg, pos_r, dir_r, pulse_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // shared divider
  assign div_dividend = cmd.div_deg ? DIV_N'(deg_mag) : DIV_N'(map_mag);
  assign div_divisor  = cmd.div_deg ? pmax_r : {{(DIV_D-RANGE_W){1'b0}}, rng_m1};

  sdpg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sts.is_dial  = (func_r == FUNC_DIAL);
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_pulse_countdown_zero : assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r |-> (cnt_r == '0))
    else $error("pulse active with nonzero countdown");

  a_zero_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && func_r == FUNC_ZERO) |=> (pos_r == '0) && !en_r && !pulse_r)
    else $error("zero event left position or motion set");

  a_idle_tick_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && func_r == FUNC_TICK && !pulse_r && !en_r) |=>
      $stable(pos_r) && $stable(cnt_r))
    else $error("tick moved a stopped motor");

endmodule

`default_nettype wire

// File: rtl/sdpg_ctrl.sv
// sequencing state machine: capture, interval map (dial events only), update, degree divide, output
`default_nettype none

module sdpg_ctrl
  import sdpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output sdpg_cmd_t      cmd,
  input  wire sdpg_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_DIV,
    S_MAP_WAIT,
    S_APPLY,
    S_DEG_MUL,
    S_DEG_DIV,
    S_DEG_WAIT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MAP_MUL;
        end
      end
      S_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_nxt   = sts.is_dial ? S_MAP_DIV : S_APPLY;
      end
      S_MAP_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_MAP_WAIT;
      end
      S_MAP_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_DEG_MUL;
      end
      S_DEG_MUL: begin
        cmd.deg_mul = 1'b1;
        state_nxt   = S_DEG_DIV;
      end
      S_DEG_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_deg   = 1'b1;
        state_nxt     = S_DEG_WAIT;
      end
      S_DEG_WAIT: begin
        cmd.div_deg = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.div_deg = 1'b1;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_done_when_waiting : assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_MAP_WAIT || state_r == S_DEG_WAIT))
    else $error("divider finished outside a wait state");

  a_one_item_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_tready)
    else $error("second item taken while one is in progress");

endmodule

`default_nettype wire
